/* design/wildcard_byte_pattern_scan_macros.svh */
// Assertion macros shared by the wildcard byte pattern scanner.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define WBPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/wbps_pkg.sv */
// Shared types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

    localparam int PAT_BYTES = 16;
    localparam int PAT_IDX_W = 4;
    localparam int CFG_W = 64;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_BASE          = 3'd0,
        CFG_PATTERN_BYTES_LOW  = 3'd1,
        CFG_PATTERN_BYTES_HIGH = 3'd2,
        CFG_CARE_MASK          = 3'd3,
        CFG_PATTERN_LENGTH     = 3'd4
    } cfg_reg_t;

    typedef logic [PAT_BYTES-1:0][7:0] wbps_pattern_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } wbps_ctrl_t;

endpackage

/* design/wbps_cell.sv */
// One window cell: holds a byte, passes it on and compares its incoming byte.
module wbps_cell
    import wbps_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int LEN_W      = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  wbps_ctrl_t           ctrl,
    input  logic [7:0]           din,
    input  wbps_pattern_t        pattern,
    input  logic [PAT_BYTES-1:0] care,
    input  logic [LEN_W-1:0]     eff_len,
    output logic [7:0]           dout,
    output logic                 ok
);

    localparam int JW = (LEN_W > 5) ? LEN_W : 5;

    logic [7:0]    byte_reg;
    logic [JW-1:0] len_ext;
    logic [JW-1:0] pos;
    logic          in_use;
    logic          wild;

    always_comb
    begin
        len_ext = JW'(eff_len);
        in_use  = len_ext > JW'(CELL_INDEX);
        pos     = len_ext - JW'(CELL_INDEX) - JW'(1);
        wild    = !in_use || (pos >= JW'(PAT_BYTES)) || !care[pos[PAT_IDX_W-1:0]];
        ok      = wild || (din == pattern[pos[PAT_IDX_W-1:0]]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else if (ctrl.clear)
        begin
            byte_reg <= 8'd0;
        end
        else if (ctrl.shift)
        begin
            byte_reg <= din;
        end
    end

    assign dout = byte_reg;

endmodule

/* design/wildcard_byte_pattern_scan.sv */
// Top level of the wildcard byte pattern scanner.
// The scanner takes one region byte per beat, one beat per cycle while not stalled, and compares
// the latest bytes against the pattern in a row of window cells in the same cycle. A compare stage
// and a tracking stage follow, so the result beat for a region passes through both registers after
// the region's last byte. Input beats stall only when a region's last byte reaches the tracking
// stage while the previous result beat is still waiting on the output.
`include "wildcard_byte_pattern_scan_macros.svh"

module wildcard_byte_pattern_scan
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_LEN = 16,
    parameter int OFFSET_BITS     = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,  // data_byte
    input  logic                 s_tlast,  // end_of_region
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata   // found, match_address, zero fill
);

    localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
    localparam int CW    = (LEN_W > 5) ? LEN_W : 5;

    logic [63:0]            scan_base_reg;
    logic [63:0]            pat_low_reg;
    logic [63:0]            pat_high_reg;
    logic [PAT_BYTES-1:0]   care_reg;
    logic [4:0]             pattern_length_reg;

    wbps_pattern_t          pattern;
    logic [CW-1:0]          len_ext;
    logic [LEN_W-1:0]       eff_len;
    wbps_ctrl_t             ctrl;
    logic                   in_accept;

    logic [MAX_PATTERN_LEN-1:0]      ok_vec;
    logic [MAX_PATTERN_LEN:0][7:0]   chain;

    logic [OFFSET_BITS-1:0] count_reg;
    logic [OFFSET_BITS-1:0] count_next;
    logic                   hit;

    logic                   s1_valid_reg;
    logic                   s1_last_reg;
    logic                   s1_hit_reg;
    logic [OFFSET_BITS-1:0] s1_offset_reg;
    logic                   s1_adv;

    logic                   seen_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   m_tvalid_reg;
    logic                   found_reg;
    logic [63:0]            addr_reg;
    logic                   found_next;
    logic [OFFSET_BITS-1:0] first_offset;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_base_reg      <= 64'd0;
            pat_low_reg        <= 64'd0;
            pat_high_reg       <= 64'd0;
            care_reg           <= '0;
            pattern_length_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SCAN_BASE:          scan_base_reg      <= cfg_wdata;
                CFG_PATTERN_BYTES_LOW:  pat_low_reg        <= cfg_wdata;
                CFG_PATTERN_BYTES_HIGH: pat_high_reg       <= cfg_wdata;
                CFG_CARE_MASK:          care_reg           <= cfg_wdata[PAT_BYTES-1:0];
                CFG_PATTERN_LENGTH:     pattern_length_reg <= cfg_wdata[4:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        for (int j = 0; j < PAT_BYTES / 2; j++)
        begin
            pattern[j]                 = pat_low_reg[8*j +: 8];
            pattern[j + PAT_BYTES / 2] = pat_high_reg[8*j +: 8];
        end
        len_ext = CW'(pattern_length_reg);
        if (len_ext == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_ext > CW'(MAX_PATTERN_LEN))
        begin
            eff_len = LEN_W'(MAX_PATTERN_LEN);
        end
        else
        begin
            eff_len = LEN_W'(len_ext);
        end
    end

    assign s1_adv    = s1_valid_reg && (!s1_last_reg || !m_tvalid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign in_accept = s_tvalid && s_tready;
    assign ctrl.shift = in_accept;
    assign ctrl.clear = in_accept && s_tlast;

    assign chain[0] = s_tdata;

    for (genvar k = 0; k < MAX_PATTERN_LEN; k++)
    begin : g_cell
        wbps_cell #(
            .CELL_INDEX (k),
            .LEN_W      (LEN_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .din     (chain[k]),
            .pattern (pattern),
            .care    (care_reg),
            .eff_len (eff_len),
            .dout    (chain[k+1]),
            .ok      (ok_vec[k])
        );
    end

    always_comb
    begin
        count_next = (count_reg != '1) ? count_reg + OFFSET_BITS'(1) : count_reg;
        hit        = (&ok_vec) && (count_next >= OFFSET_BITS'(eff_len));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_hit_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                count_reg    <= s_tlast ? '0 : count_next;
                s1_valid_reg <= 1'b1;
                s1_last_reg  <= s_tlast;
                s1_hit_reg   <= hit;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_offset_reg <= count_next - OFFSET_BITS'(eff_len);
        end
    end

    always_comb
    begin
        found_next   = seen_reg || s1_hit_reg;
        first_offset = seen_reg ? offset_reg : s1_offset_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            offset_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            if (s1_adv && s1_last_reg)
            begin
                m_tvalid_reg <= 1'b1;
                found_reg    <= found_next;
                seen_reg     <= 1'b0;
                offset_reg   <= '0;
            end
            else
            begin
                if (m_tready)
                begin
                    m_tvalid_reg <= 1'b0;
                end
                if (s1_adv && !seen_reg && s1_hit_reg)
                begin
                    seen_reg   <= 1'b1;
                    offset_reg <= s1_offset_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            addr_reg <= found_next ? scan_base_reg + 64'(first_offset) : 64'd0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, addr_reg, found_reg};

    `WBPS_ASSERT_SAME(a_no_addr_when_not_found, m_tvalid_reg && !found_reg,
        addr_reg == 64'd0, "Result beat without a match carries a nonzero address")
    `WBPS_ASSERT_NEXT(a_region_end_clears, s1_adv && s1_last_reg,
        m_tvalid_reg && !seen_reg, "Region end did not load a result and clear tracking")
    `WBPS_ASSERT_NEXT(a_count_saturates, in_accept && !s_tlast && count_reg == '1,
        count_reg == '1, "Byte count left saturation inside a region")
    `WBPS_ASSERT_SAME(a_last_waits_for_output, s1_valid_reg && s1_last_reg && m_tvalid_reg
        && !m_tready, !s1_adv, "Region end advanced over a held result beat")

endmodule
